FILE: rtl/core/cpcs_pkg.sv
package cpcs_pkg;

    localparam int VERT_W     = 60;
    localparam int NORM_W     = 16;
    localparam int NORMF_W    = 48;
    localparam int KEY_W      = 48;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int QUERY_W    = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_COS = 2'd3;

    localparam logic signed [NORM_W-1:0] WALL_COS_RESET = 16'sd2845;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        logic             cls;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic replace;
        logic drain;
    } t_cell_ctl;

    localparam t_entry ENTRY_NONE = '{valid: 1'b0, key: '0, idx: '0, cls: 1'b0};

endpackage

FILE: rtl/core/cpcs_ifs.sv
interface cpcs_tri_if;
    logic                       valid;
    logic                       ready;
    logic [cpcs_pkg::VERT_W-1:0]  vertex_a;
    logic [cpcs_pkg::VERT_W-1:0]  vertex_b;
    logic [cpcs_pkg::VERT_W-1:0]  vertex_c;
    logic [cpcs_pkg::NORMF_W-1:0] face_normal;
    logic                       end_of_set;
    modport source (output valid, vertex_a, vertex_b, vertex_c, face_normal, end_of_set,
                    input ready);
    modport sink (input valid, vertex_a, vertex_b, vertex_c, face_normal, end_of_set,
                  output ready);
endinterface

interface cpcs_res_if;
    logic                       valid;
    logic                       ready;
    logic [cpcs_pkg::IDX_W-1:0] poly_index;
    logic                       is_wall;
    logic [cpcs_pkg::KEY_W-1:0] distance_key;
    logic                       found;
    logic                       overflow;
    logic                       last_result;
    modport source (output valid, poly_index, is_wall, distance_key, found, overflow,
                    last_result, input ready);
    modport sink (input valid, poly_index, is_wall, distance_key, found, overflow,
                  last_result, output ready);
endinterface

interface cpcs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cpcs_pkg::CFG_IDX_W-1:0]  index;
    logic [cpcs_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cpcs_front.sv
module cpcs_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cpcs_pkg::VERT_W-1:0]       i_vertex_a,
    input  logic [cpcs_pkg::VERT_W-1:0]       i_vertex_b,
    input  logic [cpcs_pkg::VERT_W-1:0]       i_vertex_c,
    input  logic [cpcs_pkg::NORMF_W-1:0]      i_face_normal,
    input  logic [cpcs_pkg::QUERY_W-1:0]      i_query_x,
    input  logic [cpcs_pkg::QUERY_W-1:0]      i_query_y,
    input  logic [cpcs_pkg::QUERY_W-1:0]      i_query_z,
    input  logic signed [cpcs_pkg::NORM_W-1:0] i_wall_cos,
    output logic                              o_valid,
    output logic                              o_keep,
    output logic                              o_cls,
    output logic [cpcs_pkg::KEY_W-1:0]        o_key
);

    localparam int C     = COORD_BITS;
    localparam int T_W   = C + 3;
    localparam int D_W   = C + 1;
    localparam int TSQ_W = 2 * T_W;
    localparam int DSQ_W = 2 * D_W;
    localparam int PRD_W = cpcs_pkg::NORM_W + T_W;
    localparam int DOT_W = PRD_W + 2;
    localparam int KW    = cpcs_pkg::KEY_W;

    logic signed [C-1:0]                w_a [3];
    logic signed [C-1:0]                w_b [3];
    logic signed [C-1:0]                w_c [3];
    logic signed [C-1:0]                w_q [3];
    logic signed [cpcs_pkg::NORM_W-1:0] w_n [3];

    logic signed [T_W-1:0]              r_t  [3];
    logic signed [D_W-1:0]              r_da [3];
    logic signed [D_W-1:0]              r_db [3];
    logic signed [D_W-1:0]              r_dc [3];
    logic signed [cpcs_pkg::NORM_W-1:0] r_n  [3];

    logic signed [TSQ_W-1:0] r_tsq [3];
    logic signed [DSQ_W-1:0] r_asq [3];
    logic signed [DSQ_W-1:0] r_bsq [3];
    logic signed [DSQ_W-1:0] r_csq [3];
    logic signed [PRD_W-1:0] r_prd [3];

    logic [KW-1:0]           r_ksum_t;
    logic [KW-1:0]           r_ksum_a;
    logic [KW-1:0]           r_ksum_b;
    logic [KW-1:0]           r_ksum_c;
    logic signed [DOT_W-1:0] r_dot;

    logic [KW-1:0] w_sa;
    logic [KW-1:0] w_sb;
    logic [KW-1:0] w_sc;
    logic [KW-1:0] w_m0;
    logic [KW-1:0] w_m1;

    logic r_v0, r_v1, r_v2, r_v3;
    logic r_cls0, r_cls1, r_cls2, r_cls3;
    logic r_keep;
    logic [KW-1:0] r_key;

    always_comb begin
        w_q[0] = i_query_x[C-1:0];
        w_q[1] = i_query_y[C-1:0];
        w_q[2] = i_query_z[C-1:0];
        for (int k = 0; k < 3; k++) begin
            w_a[k] = i_vertex_a[k*C +: C];
            w_b[k] = i_vertex_b[k*C +: C];
            w_c[k] = i_vertex_c[k*C +: C];
            w_n[k] = i_face_normal[k*cpcs_pkg::NORM_W +: cpcs_pkg::NORM_W];
        end
    end

    always_comb begin
        w_sa = KW'($unsigned(r_asq[0])) + KW'($unsigned(r_asq[1]))
             + KW'($unsigned(r_asq[2]));
        w_sb = KW'($unsigned(r_bsq[0])) + KW'($unsigned(r_bsq[1]))
             + KW'($unsigned(r_bsq[2]));
        w_sc = KW'($unsigned(r_csq[0])) + KW'($unsigned(r_csq[1]))
             + KW'($unsigned(r_csq[2]));
        w_m0 = (r_ksum_a < r_ksum_t) ? r_ksum_a : r_ksum_t;
        w_m1 = (r_ksum_c < r_ksum_b) ? r_ksum_c : r_ksum_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_t[k]  <= T_W'(w_q[k]) + T_W'(w_q[k]) + T_W'(w_q[k])
                     - T_W'(w_a[k]) - T_W'(w_b[k]) - T_W'(w_c[k]);
            r_da[k] <= D_W'(w_q[k]) - D_W'(w_a[k]);
            r_db[k] <= D_W'(w_q[k]) - D_W'(w_b[k]);
            r_dc[k] <= D_W'(w_q[k]) - D_W'(w_c[k]);
            r_n[k]  <= w_n[k];
            r_tsq[k] <= r_t[k] * r_t[k];
            r_asq[k] <= r_da[k] * r_da[k];
            r_bsq[k] <= r_db[k] * r_db[k];
            r_csq[k] <= r_dc[k] * r_dc[k];
            r_prd[k] <= PRD_W'(r_n[k]) * PRD_W'(r_t[k]);
        end
        r_cls0 <= (w_n[1] < i_wall_cos);
        r_cls1 <= r_cls0;
        r_cls2 <= r_cls1;
        r_cls3 <= r_cls2;
        r_ksum_t <= KW'($unsigned(r_tsq[0])) + KW'($unsigned(r_tsq[1]))
                  + KW'($unsigned(r_tsq[2]));
        r_ksum_a <= (w_sa << 3) + w_sa;
        r_ksum_b <= (w_sb << 3) + w_sb;
        r_ksum_c <= (w_sc << 3) + w_sc;
        r_dot    <= DOT_W'(r_prd[0]) + DOT_W'(r_prd[1]) + DOT_W'(r_prd[2]);
        r_key    <= (w_m1 < w_m0) ? w_m1 : w_m0;
        r_keep   <= !r_dot[DOT_W-1];
    end

    assign o_valid = r_v3;
    assign o_keep  = r_keep;
    assign o_cls   = r_cls3;
    assign o_key   = r_key;

endmodule

FILE: rtl/core/cpcs_cell.sv
module cpcs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpcs_pkg::t_cell_ctl i_ctl,
    input  cpcs_pkg::t_entry    i_new,
    input  cpcs_pkg::t_entry    i_prev,
    input  cpcs_pkg::t_entry    i_next,
    input  logic                i_prev_prec,
    output cpcs_pkg::t_entry    o_entry,
    output logic                o_prec,
    output logic                o_match
);

    cpcs_pkg::t_entry r_entry;

    assign o_entry = r_entry;
    assign o_prec  = r_entry.valid && ((r_entry.cls && !i_new.cls) ||
                     (r_entry.cls == i_new.cls && r_entry.key < i_new.key));
    assign o_match = r_entry.valid && r_entry.cls == i_new.cls && r_entry.key == i_new.key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_ctl.drain) begin
            r_entry <= i_next;
        end else if (i_ctl.replace) begin
            if (o_match) begin
                r_entry.idx <= i_new.idx;
            end
        end else if (i_ctl.insert && !o_prec) begin
            r_entry <= i_prev_prec ? i_new : i_prev;
        end
    end

endmodule

FILE: rtl/core/contact_poly_classify_sort_top.sv
// Collects one set of collision triangles and returns the kept ones sorted,
// walls first, then floors, each class in ascending distance key.
// Channels: i_cfg writes the query point and the wall cosine limit; the user
// must write them only while the block is idle, which the block does not
// enforce; i_tri takes one triangle per request; o_res returns results. A
// triangle runs through a four-stage distance unit (differences, products,
// sums, minimum) and is then inserted into a row of MAX_POLYS sort cells, and
// no new request is taken before then. An item past capacity is only flagged.
// The request marked end_of_set starts the drain: the cell row shifts toward
// its head one entry per cycle, giving one result per cycle into a single
// output register; an empty set gives one result with found low.
// When the receiver stalls, the output register holds its result and the
// row stops shifting; no request is taken until the set has drained.
// Reset clears the cell row, arrival counter, overflow flag and query registers
// (query 0, wall cosine limit 2845), and leaves the block idle and ready.
module contact_poly_classify_sort_top #(
    parameter int MAX_POLYS  = 32,
    parameter int COORD_BITS = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cpcs_cfg_if.sink   i_cfg,
    cpcs_tri_if.sink   i_tri,
    cpcs_res_if.source o_res
);

    localparam int CNT_W = $clog2(MAX_POLYS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN
    } t_state;

    t_state r_state;

    logic [cpcs_pkg::QUERY_W-1:0]       r_query_x;
    logic [cpcs_pkg::QUERY_W-1:0]       r_query_y;
    logic [cpcs_pkg::QUERY_W-1:0]       r_query_z;
    logic signed [cpcs_pkg::NORM_W-1:0] r_wall_cos;

    logic [CNT_W-1:0]          r_arrival;
    logic [cpcs_pkg::IDX_W-1:0] r_cur_idx;
    logic                      r_end;
    logic                      r_ovf;

    logic                       r_out_valid;
    logic [cpcs_pkg::IDX_W-1:0] r_out_idx;
    logic                       r_out_wall;
    logic [cpcs_pkg::KEY_W-1:0] r_out_key;
    logic                       r_out_found;
    logic                       r_out_ovf;
    logic                       r_out_last;

    logic w_acc;
    logic w_room;
    logic w_load;
    logic w_last;
    logic w_any_match;
    logic w_full;

    logic                       f_valid;
    logic                       f_keep;
    logic                       f_cls;
    logic [cpcs_pkg::KEY_W-1:0] f_key;

    cpcs_pkg::t_cell_ctl w_ctl;
    cpcs_pkg::t_entry    w_new;
    cpcs_pkg::t_entry    w_entry [MAX_POLYS+1];
    logic [MAX_POLYS-1:0] w_prec;
    logic [MAX_POLYS-1:0] w_match;

    assign i_cfg.ready = 1'b1;
    assign i_tri.ready = (r_state == ST_IDLE);
    assign w_acc  = i_tri.valid && i_tri.ready;
    assign w_room = (r_arrival < CNT_W'(MAX_POLYS));
    assign w_load = !r_out_valid || o_res.ready;
    assign w_last = !w_entry[1].valid;
    assign w_any_match = |w_match;
    assign w_full = w_entry[MAX_POLYS-1].valid;

    assign w_new = '{valid: 1'b1, key: f_key, idx: r_cur_idx, cls: f_cls};
    assign w_entry[MAX_POLYS] = cpcs_pkg::ENTRY_NONE;

    always_comb begin
        w_ctl.insert  = (r_state == ST_CALC) && f_valid && f_keep && !w_any_match && !w_full;
        w_ctl.replace = (r_state == ST_CALC) && f_valid && f_keep && w_any_match;
        w_ctl.drain   = (r_state == ST_DRAIN) && w_load;
    end

    cpcs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_acc && w_room),
        .i_vertex_a    (i_tri.vertex_a),
        .i_vertex_b    (i_tri.vertex_b),
        .i_vertex_c    (i_tri.vertex_c),
        .i_face_normal (i_tri.face_normal),
        .i_query_x     (r_query_x),
        .i_query_y     (r_query_y),
        .i_query_z     (r_query_z),
        .i_wall_cos    (r_wall_cos),
        .o_valid       (f_valid),
        .o_keep        (f_keep),
        .o_cls         (f_cls),
        .o_key         (f_key)
    );

    for (genvar g = 0; g < MAX_POLYS; g++) begin : g_cell
        cpcs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new       (w_new),
            .i_prev      ((g == 0) ? cpcs_pkg::ENTRY_NONE : w_entry[(g == 0) ? 0 : g-1]),
            .i_next      (w_entry[g+1]),
            .i_prev_prec ((g == 0) ? 1'b1 : w_prec[(g == 0) ? 0 : g-1]),
            .o_entry     (w_entry[g]),
            .o_prec      (w_prec[g]),
            .o_match     (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x  <= '0;
            r_query_y  <= '0;
            r_query_z  <= '0;
            r_wall_cos <= cpcs_pkg::WALL_COS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                cpcs_pkg::CFG_QUERY_X:  r_query_x  <= i_cfg.data;
                cpcs_pkg::CFG_QUERY_Y:  r_query_y  <= i_cfg.data;
                cpcs_pkg::CFG_QUERY_Z:  r_query_z  <= i_cfg.data;
                cpcs_pkg::CFG_WALL_COS: r_wall_cos <= i_cfg.data[cpcs_pkg::NORM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_arrival   <= '0;
            r_ovf       <= 1'b0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctl.drain) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_end <= i_tri.end_of_set;
                        if (w_room) begin
                            r_cur_idx <= cpcs_pkg::IDX_W'(r_arrival);
                            r_arrival <= r_arrival + CNT_W'(1);
                            r_state   <= ST_CALC;
                        end else begin
                            r_ovf   <= 1'b1;
                            r_state <= i_tri.end_of_set ? ST_DRAIN : ST_IDLE;
                        end
                    end
                end
                ST_CALC: begin
                    if (f_valid) begin
                        r_state <= r_end ? ST_DRAIN : ST_IDLE;
                    end
                end
                ST_DRAIN: begin
                    if (w_load) begin
                        r_out_found <= w_entry[0].valid;
                        r_out_idx   <= w_entry[0].valid ? w_entry[0].idx : '0;
                        r_out_wall  <= w_entry[0].valid && w_entry[0].cls;
                        r_out_key   <= w_entry[0].valid ? w_entry[0].key : '0;
                        r_out_ovf   <= r_ovf;
                        r_out_last  <= w_last;
                        if (w_last) begin
                            r_arrival <= '0;
                            r_ovf     <= 1'b0;
                            r_state   <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.poly_index   = r_out_idx;
    assign o_res.is_wall      = r_out_wall;
    assign o_res.distance_key = r_out_key;
    assign o_res.found        = r_out_found;
    assign o_res.overflow     = r_out_ovf;
    assign o_res.last_result  = r_out_last;

endmodule

FILE: sim/contact_poly_classify_sort_top_tb.sv
`timescale 1ns / 1ps

module contact_poly_classify_sort_top_tb;

    localparam int MAXP = 32;
    localparam int CB = 20;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic [cpcs_pkg::VERT_W-1:0]  va;
        logic [cpcs_pkg::VERT_W-1:0]  vb;
        logic [cpcs_pkg::VERT_W-1:0]  vc;
        logic [cpcs_pkg::NORMF_W-1:0] nrm;
        logic                         eos;
    } t_tri;

    typedef struct {
        logic [cpcs_pkg::IDX_W-1:0] idx;
        logic                       wall;
        logic [cpcs_pkg::KEY_W-1:0] key;
        logic                       found;
        logic                       ovf;
        logic                       last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cpcs_cfg_if cfg_if ();
    cpcs_tri_if tri_if ();
    cpcs_res_if res_if ();

    contact_poly_classify_sort_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_tri   (tri_if.sink),
        .o_res   (res_if.source)
    );

    t_tri tri_q[$];
    t_res sorted_q[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;
    bit   cfg_busy = 1'b0;
    logic [cpcs_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [cpcs_pkg::CFG_DATA_W-1:0] cfg_data;

    logic signed [CB-1:0]               qx = '0, qy = '0, qz = '0;
    logic signed [cpcs_pkg::NORM_W-1:0] cos_lim = cpcs_pkg::WALL_COS_RESET;
    logic [cpcs_pkg::KEY_W-1:0] st_key[MAXP];
    logic [cpcs_pkg::IDX_W-1:0] st_idx[MAXP];
    logic                       st_cls[MAXP];
    int kept = 0;
    int arrived = 0;
    bit ovf_flag = 1'b0;

    initial forever #4 i_clk = ~i_clk;

    function automatic longint sq_dist(longint dx, longint dy, longint dz);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic sort_in(logic [cpcs_pkg::KEY_W-1:0] key, logic [cpcs_pkg::IDX_W-1:0] idx,
                           logic cls);
        int pos;
        pos = 0;
        while (pos < kept && (st_cls[pos] > cls || (st_cls[pos] == cls && st_key[pos] < key)))
            pos++;
        if (pos < kept && st_cls[pos] == cls && st_key[pos] == key) begin
            st_idx[pos] = idx;
            return;
        end
        if (kept >= MAXP) return;
        for (int i = kept; i > pos; i--) begin
            st_key[i] = st_key[i-1];
            st_idx[i] = st_idx[i-1];
            st_cls[i] = st_cls[i-1];
        end
        st_key[pos] = key;
        st_idx[pos] = idx;
        st_cls[pos] = cls;
        kept++;
    endtask

    task automatic predict_sort(t_tri t);
        longint a[3], b[3], c[3], n[3], q[3], d[3];
        longint dot, key, k;
        t_res r;
        if (arrived < MAXP) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = longint'($signed(t.va[i*CB +: CB]));
                b[i] = longint'($signed(t.vb[i*CB +: CB]));
                c[i] = longint'($signed(t.vc[i*CB +: CB]));
                n[i] = longint'($signed(t.nrm[i*16 +: 16]));
            end
            q[0] = qx; q[1] = qy; q[2] = qz;
            for (int i = 0; i < 3; i++) d[i] = 3 * q[i] - (a[i] + b[i] + c[i]);
            dot = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
            if (dot >= 0) begin
                key = sq_dist(d[0], d[1], d[2]);
                k = 9 * sq_dist(q[0] - a[0], q[1] - a[1], q[2] - a[2]);
                if (k < key) key = k;
                k = 9 * sq_dist(q[0] - b[0], q[1] - b[1], q[2] - b[2]);
                if (k < key) key = k;
                k = 9 * sq_dist(q[0] - c[0], q[1] - c[1], q[2] - c[2]);
                if (k < key) key = k;
                sort_in(key[cpcs_pkg::KEY_W-1:0], arrived[cpcs_pkg::IDX_W-1:0],
                        n[1] < longint'(cos_lim));
            end
            arrived++;
        end else begin
            ovf_flag = 1'b1;
        end
        if (!t.eos) return;
        if (kept == 0) begin
            r = '{idx: '0, wall: 1'b0, key: '0, found: 1'b0, ovf: ovf_flag, last: 1'b1};
            sorted_q.insert(sorted_q.size(), r);
        end else begin
            for (int i = 0; i < kept; i++) begin
                r = '{idx: st_idx[i], wall: st_cls[i], key: st_key[i], found: 1'b1,
                      ovf: ovf_flag, last: (i == kept - 1)};
                sorted_q.insert(sorted_q.size(), r);
            end
        end
        kept = 0;
        arrived = 0;
        ovf_flag = 1'b0;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    function automatic logic [cpcs_pkg::VERT_W-1:0] rand_vert(int span);
        logic [cpcs_pkg::VERT_W-1:0] v;
        for (int i = 0; i < 3; i++) begin
            if (span == 0) v[i*CB +: CB] = CB'($urandom);
            else v[i*CB +: CB] = CB'($urandom_range(2 * span) - span);
        end
        return v;
    endfunction

    function automatic logic [cpcs_pkg::NORMF_W-1:0] rand_norm();
        logic [cpcs_pkg::NORMF_W-1:0] v;
        case ($urandom_range(3))
            0: v = cpcs_pkg::NORMF_W'({$urandom, $urandom});
            1: v = {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                    16'($urandom_range(32768) - 16384)};
            2: v = {16'sd0, 16'sd16384, 16'sd0};
            default: v = {16'($urandom_range(8000) - 4000), 16'($urandom_range(6000)),
                          16'($urandom_range(8000) - 4000)};
        endcase
        return v;
    endfunction

    task automatic add_tri(logic [cpcs_pkg::VERT_W-1:0] a, logic [cpcs_pkg::VERT_W-1:0] b,
                           logic [cpcs_pkg::VERT_W-1:0] c, logic [cpcs_pkg::NORMF_W-1:0] n,
                           logic e);
        t_tri t;
        t = '{va: a, vb: b, vc: c, nrm: n, eos: e};
        tri_q.insert(tri_q.size(), t);
    endtask

    task automatic write_reg(logic [cpcs_pkg::CFG_IDX_W-1:0] idx,
                             logic [cpcs_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_idx = idx;
        cfg_data = data;
        cfg_busy = 1'b1;
        do @(negedge i_clk); while (cfg_busy);
        case (idx)
            cpcs_pkg::CFG_QUERY_X: qx = data[CB-1:0];
            cpcs_pkg::CFG_QUERY_Y: qy = data[CB-1:0];
            cpcs_pkg::CFG_QUERY_Z: qz = data[CB-1:0];
            cpcs_pkg::CFG_WALL_COS: cos_lim = data[cpcs_pkg::NORM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_wait();
        while (tri_q.size() != 0 || sorted_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        cfg_if.valid <= cfg_busy;
        cfg_if.index <= cfg_idx;
        cfg_if.data <= cfg_data;
    end

    always @(posedge i_clk) begin
        if (cfg_if.valid && cfg_if.ready) cfg_busy <= 1'b0;
    end

    int tx_gap = 0;
    int rx_gap = 0;

    initial begin
        cfg_busy = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        tri_if.valid = 1'b0;
        tri_if.vertex_a = '0;
        tri_if.vertex_b = '0;
        tri_if.vertex_c = '0;
        tri_if.face_normal = '0;
        tri_if.end_of_set = 1'b0;
        res_if.ready = 1'b0;
    end

    bit tri_taken = 1'b0;

    always @(posedge i_clk) begin
        tri_taken <= tri_if.valid && tri_if.ready && i_rst_n;
        if (tri_if.valid && tri_if.ready && i_rst_n) begin
            predict_sort(tri_q.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (tx_gap > 0) begin
                tx_gap--;
                if (tri_taken || !tri_if.valid) tri_if.valid <= 1'b0;
            end else if (tri_if.valid && !tri_taken) begin
            end else if (tri_q.size() != 0) begin
                if (!quiet && $urandom_range(7) == 0) begin
                    tx_gap = $urandom_range(1, 10);
                    tri_if.valid <= 1'b0;
                end else begin
                    tri_if.valid <= 1'b1;
                    tri_if.vertex_a <= tri_q[0].va;
                    tri_if.vertex_b <= tri_q[0].vb;
                    tri_if.vertex_c <= tri_q[0].vc;
                    tri_if.face_normal <= tri_q[0].nrm;
                    tri_if.end_of_set <= tri_q[0].eos;
                end
            end else begin
                tri_if.valid <= 1'b0;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(7) == 0) begin
                rx_gap = $urandom_range(1, 10);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (sorted_q.size() == 0) begin
                report("unexpected result", 64'(res_if.poly_index), 64'd0);
            end else begin
                e = sorted_q.pop_front();
                if (res_if.poly_index !== e.idx)
                    report("poly_index", 64'(res_if.poly_index), 64'(e.idx));
                if (res_if.is_wall !== e.wall)
                    report("is_wall", 64'(res_if.is_wall), 64'(e.wall));
                if (res_if.distance_key !== e.key)
                    report("distance_key", 64'(res_if.distance_key), 64'(e.key));
                if (res_if.found !== e.found)
                    report("found", 64'(res_if.found), 64'(e.found));
                if (res_if.overflow !== e.ovf)
                    report("overflow", 64'(res_if.overflow), 64'(e.ovf));
                if (res_if.last_result !== e.last)
                    report("last_result", 64'(res_if.last_result), 64'(e.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tri_if.valid && tri_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("** contact_poly_classify_sort_top: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [cpcs_pkg::VERT_W-1:0] p;
        int n_set;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        add_tri('0, '0, '0, '0, 1'b1);
        add_tri({3{20'h7FFFF}}, {3{20'h80000}}, {3{20'hFFFFF}},
                {16'h7FFF, 16'h8000, 16'hFFFF}, 1'b0);
        add_tri({3{20'h80000}}, {3{20'h7FFFF}}, {3{20'h00001}}, {3{16'h8000}}, 1'b0);
        add_tri({3{20'h00010}}, {3{20'h00020}}, '0, {16'd0, 16'sd16384, 16'd0}, 1'b0);
        add_tri({3{20'h00010}}, {3{20'h00020}}, '0, {16'd0, 16'sd16384, 16'd0}, 1'b0);
        add_tri({3{20'h00010}}, {3{20'h00020}}, '0, {16'd0, 16'sd100, 16'd0}, 1'b0);
        add_tri({3{20'h00030}}, '0, '0, {16'd0, 16'sd2845, 16'd0}, 1'b0);
        add_tri('0, '0, '0, {16'd0, 16'sd2844, 16'd0}, 1'b1);
        add_tri({20'd0, 20'd1, 20'd0}, {20'd0, 20'hFFFFF, 20'd0}, '0,
                {16'd0, 16'd0, 16'sd9}, 1'b1);
        add_tri({3{20'h00100}}, '0, '0, {16'd0, 16'hC000, 16'd0}, 1'b1);
        for (int i = 0; i < 34; i++)
            add_tri(rand_vert(0), rand_vert(0), rand_vert(0), rand_norm(), i == 33);
        drain_wait();

        write_reg(cpcs_pkg::CFG_QUERY_X, 20'h7FFFF);
        write_reg(cpcs_pkg::CFG_QUERY_Y, 20'h80000);
        write_reg(cpcs_pkg::CFG_QUERY_Z, 20'hFFFFF);
        write_reg(cpcs_pkg::CFG_WALL_COS, 20'h04000);
        for (int i = 0; i < 4; i++)
            add_tri(rand_vert(0), rand_vert(0), rand_vert(0), rand_norm(), i == 3);
        drain_wait();
        write_reg(cpcs_pkg::CFG_WALL_COS, 20'h0C000);
        write_reg(cpcs_pkg::CFG_QUERY_X, 20'h80000);
        write_reg(cpcs_pkg::CFG_QUERY_Y, 20'h7FFFF);
        for (int i = 0; i < 4; i++)
            add_tri(rand_vert(0), rand_vert(0), rand_vert(0), rand_norm(), i == 3);
        drain_wait();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(cpcs_pkg::CFG_QUERY_X,
                      cpcs_pkg::CFG_DATA_W'($urandom_range(400) - 200));
            write_reg(cpcs_pkg::CFG_QUERY_Y,
                      cpcs_pkg::CFG_DATA_W'($urandom_range(400) - 200));
            write_reg(cpcs_pkg::CFG_QUERY_Z,
                      cpcs_pkg::CFG_DATA_W'($urandom_range(400) - 200));
            write_reg(cpcs_pkg::CFG_WALL_COS,
                      cpcs_pkg::CFG_DATA_W'($urandom_range(32768) - 16384));
            if (ph == 3) quiet = 1'b1;
            for (int s = 0; s < 12; s++) begin
                n_set = ($urandom_range(9) == 0) ? $urandom_range(33, 36)
                                                 : $urandom_range(1, 12);
                for (int i = 0; i < n_set; i++) begin
                    p = rand_vert(200);
                    if ($urandom_range(5) == 0)
                        add_tri(p, p, p, rand_norm(), i == n_set - 1);
                    else if ($urandom_range(9) == 0)
                        add_tri(rand_vert(0), rand_vert(0), rand_vert(0), rand_norm(),
                                i == n_set - 1);
                    else
                        add_tri(p, rand_vert(200), rand_vert(200), rand_norm(),
                                i == n_set - 1);
                end
            end
            drain_wait();
        end

        if (errors == 0)
            $display("** contact_poly_classify_sort_top: PASSED **");
        else
            $display("** contact_poly_classify_sort_top: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cpcs_pkg.sv
rtl/core/cpcs_ifs.sv
rtl/core/cpcs_front.sv
rtl/core/cpcs_cell.sv
rtl/core/contact_poly_classify_sort_top.sv
sim/contact_poly_classify_sort_top_tb.sv
